[sv/nep_pkg.sv]
package nep_pkg;

   localparam int unsigned PW    = 36;
   localparam int unsigned EW    = 40;
   localparam int unsigned MW    = 37;
   localparam int unsigned VW    = 64;
   localparam int unsigned RTW   = 32;
   localparam int unsigned REMW  = 36;
   localparam int unsigned SW    = 35;
   localparam int unsigned QW    = 32;
   localparam int unsigned LANES = 3;

   localparam logic signed [EW-1:0] ONE_Q30 = EW'(64'sd1073741824);
   localparam logic signed [EW-1:0] ARG_MAX = EW'(64'sd68719476735);

   typedef enum logic [1:0] {
      BIG_W,
      BIG_X,
      BIG_Y,
      BIG_Z
   } big_type;

   typedef struct packed {
      logic signed [31:0] pos_north;
      logic signed [31:0] pos_east;
      logic signed [31:0] pos_down;
      logic signed [31:0] att_w;
      logic signed [31:0] att_x;
      logic signed [31:0] att_y;
      logic signed [31:0] att_z;
   } in_type;

   typedef struct packed {
      logic [31:0] east;
      logic [31:0] north;
      logic [31:0] up;
   } pos_type;

   typedef struct packed {
      logic [31:0] w;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } quat_type;

   typedef struct packed {
      pos_type                  pos;
      big_type                  big;
      logic                     zero;
      logic                     wide;
      logic [LANES-1:0]         neg;
      logic [LANES-1:0][MW-1:0] mag;
   } side_type;

   typedef struct packed {
      logic [VW-1:0] rad;
      side_type      side;
   } fr_type;

   typedef struct packed {
      logic [REMW-1:0] rem;
      logic [RTW-1:0]  root;
      logic [VW-1:0]   rad;
      side_type        side;
   } sq_type;

   typedef struct packed {
      logic [RTW-1:0] root;
      side_type       side;
   } rt_type;

   typedef struct packed {
      logic [LANES-1:0][REMW-1:0] rem;
      logic [LANES-1:0][QW-1:0]   quo;
      logic [LANES-1:0]           ovf;
      logic [SW-1:0]              s;
      side_type                   side;
   } dv_type;

   typedef struct packed {
      pos_type  pos;
      quat_type att;
   } out_type;

endpackage

[sv/nep_if.sv]
interface nep_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_north;
   logic signed [31:0] pos_east;
   logic signed [31:0] pos_down;
   logic signed [31:0] att_w;
   logic signed [31:0] att_x;
   logic signed [31:0] att_y;
   logic signed [31:0] att_z;

   modport source (output valid, pos_north, pos_east, pos_down, att_w, att_x, att_y, att_z,
                   input ready);
   modport sink (input valid, pos_north, pos_east, pos_down, att_w, att_x, att_y, att_z,
                 output ready);
endinterface

interface nep_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] enu_east;
   logic signed [31:0] enu_north;
   logic signed [31:0] enu_up;
   logic signed [31:0] out_w;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;

   modport source (output valid, enu_east, enu_north, enu_up, out_w, out_x, out_y, out_z,
                   input ready);
   modport sink (input valid, enu_east, enu_north, enu_up, out_w, out_x, out_y, out_z,
                 output ready);
endinterface

[sv/nep_front.sv]
module nep_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  nep_pkg::in_type in_data,
   output logic            out_valid,
   output nep_pkg::fr_type out_data
);
   import nep_pkg::*;

   localparam int XX = 0, YY = 1, ZZ = 2, WX = 3, WY = 4, WZ = 5, XY = 6, XZ = 7, YZ = 8;
   localparam int M00 = 0, M01 = 1, M02 = 2, M10 = 3, M11 = 4, M12 = 5;
   localparam int M20 = 6, M21 = 7, M22 = 8;

   logic signed [63:0]   prod [9];
   logic signed [PW-1:0] pq_in [9];
   logic signed [PW-1:0] pq_ff [9];
   logic signed [EW-1:0] e [9];
   logic signed [EW-1:0] m_in [9];
   logic signed [EW-1:0] m_ff [9];
   pos_type              pos_in, pos1_ff, pos2_ff;
   logic                 v1_ff, v2_ff, v3_ff;

   logic signed [EW-1:0] tr, arg, nw, ny, nz, pxy, pxz, pyz;
   logic signed [EW-1:0] num [LANES];
   logic [35:0]          a36;
   big_type              big;
   fr_type               fr_in, fr_ff;

   always_comb begin
      prod[XX] = in_data.att_x * in_data.att_x;
      prod[YY] = in_data.att_y * in_data.att_y;
      prod[ZZ] = in_data.att_z * in_data.att_z;
      prod[WX] = in_data.att_w * in_data.att_x;
      prod[WY] = in_data.att_w * in_data.att_y;
      prod[WZ] = in_data.att_w * in_data.att_z;
      prod[XY] = in_data.att_x * in_data.att_y;
      prod[XZ] = in_data.att_x * in_data.att_z;
      prod[YZ] = in_data.att_y * in_data.att_z;
      for (int i = 0; i < 9; i++) begin
         pq_in[i] = PW'(prod[i] >>> 30);
      end
      pos_in.east  = in_data.pos_east;
      pos_in.north = in_data.pos_north;
      pos_in.up    = (in_data.pos_down == 32'sh80000000) ? 32'h7FFFFFFF : -in_data.pos_down;
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = EW'(pq_ff[i]);
      end
      m_in[M00] = (e[XY] + e[WZ]) <<< 1;
      m_in[M01] = ((e[XX] + e[ZZ]) <<< 1) - ONE_Q30;
      m_in[M02] = (e[WX] - e[YZ]) <<< 1;
      m_in[M10] = ONE_Q30 - ((e[YY] + e[ZZ]) <<< 1);
      m_in[M11] = (e[WZ] - e[XY]) <<< 1;
      m_in[M12] = -((e[XZ] + e[WY]) <<< 1);
      m_in[M20] = (e[WY] - e[XZ]) <<< 1;
      m_in[M21] = (e[YZ] + e[WX]) <<< 1;
      m_in[M22] = ONE_Q30 - ((e[XX] + e[YY]) <<< 1);
   end

   always_comb begin
      tr  = m_ff[M00] + m_ff[M11] + m_ff[M22];
      nw  = m_ff[M21] - m_ff[M12];
      ny  = m_ff[M02] - m_ff[M20];
      nz  = m_ff[M10] - m_ff[M01];
      pxy = m_ff[M01] + m_ff[M10];
      pxz = m_ff[M02] + m_ff[M20];
      pyz = m_ff[M12] + m_ff[M21];
      if (!tr[EW-1] && tr != '0) begin
         big = BIG_W;
         arg = tr + ONE_Q30;
      end else if (m_ff[M00] > m_ff[M11] && m_ff[M00] > m_ff[M22]) begin
         big = BIG_X;
         arg = ONE_Q30 + m_ff[M00] - m_ff[M11] - m_ff[M22];
      end else if (m_ff[M11] > m_ff[M22]) begin
         big = BIG_Y;
         arg = ONE_Q30 + m_ff[M11] - m_ff[M00] - m_ff[M22];
      end else begin
         big = BIG_Z;
         arg = ONE_Q30 + m_ff[M22] - m_ff[M00] - m_ff[M11];
      end
      unique case (big)
         BIG_W: begin
            num[0] = nw;
            num[1] = ny;
            num[2] = nz;
         end
         BIG_X: begin
            num[0] = nw;
            num[1] = pxy;
            num[2] = pxz;
         end
         BIG_Y: begin
            num[0] = ny;
            num[1] = pxy;
            num[2] = pyz;
         end
         BIG_Z: begin
            num[0] = nz;
            num[1] = pxz;
            num[2] = pyz;
         end
      endcase
      a36 = (arg > ARG_MAX) ? '1 : arg[35:0];
      fr_in.side.pos  = pos2_ff;
      fr_in.side.big  = big;
      fr_in.side.zero = arg[EW-1] || arg == '0;
      fr_in.side.wide = |a36[35:34];
      fr_in.rad       = fr_in.side.wide ? {a36, 28'd0} : {a36[33:0], 30'd0};
      for (int l = 0; l < LANES; l++) begin
         fr_in.side.neg[l] = num[l][EW-1];
         fr_in.side.mag[l] = MW'(num[l][EW-1] ? -num[l] : num[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            pq_ff[i] <= pq_in[i];
            m_ff[i]  <= m_in[i];
         end
         pos1_ff <= pos_in;
         pos2_ff <= pos1_ff;
         fr_ff   <= fr_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = fr_ff;

endmodule

[sv/nep_sqrt.sv]
module nep_sqrt (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  nep_pkg::fr_type in_data,
   output logic            out_valid,
   output nep_pkg::rt_type out_data
);
   import nep_pkg::*;

   sq_type         src [RTW];
   sq_type         st_in [RTW];
   sq_type         st_ff [RTW];
   logic [RTW-1:0] v_ff;

   for (genvar k = 0; k < RTW; k++) begin : g_step
      localparam int P = RTW - 1 - k;
      logic [REMW-1:0] rem_sh, trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign src[k] = '{rem: '0, root: '0, rad: in_data.rad, side: in_data.side};
      end else begin : g_next
         assign src[k] = st_ff[k-1];
      end

      always_comb begin
         rem_sh           = {src[k].rem[REMW-3:0], src[k].rad[2*P+1 -: 2]};
         trial            = REMW'({src[k].root, 2'b01});
         ge               = rem_sh >= trial;
         st_in[k]         = src[k];
         st_in[k].rem     = ge ? rem_sh - trial : rem_sh;
         st_in[k].root    = {src[k].root[RTW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RTW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RTW; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid      = v_ff[RTW-1];
   assign out_data.root  = st_ff[RTW-1].root;
   assign out_data.side  = st_ff[RTW-1].side;

endmodule

[sv/nep_div.sv]
module nep_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  nep_pkg::rt_type  in_data,
   output logic             out_valid,
   output nep_pkg::out_type out_data
);
   import nep_pkg::*;

   function automatic logic [31:0] lane_fix(logic [QW-1:0] q, logic ovf, logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (ovf || q > 32'h80000000) ? 32'h80000000 : -q;
      end else begin
         r = (ovf || q[QW-1]) ? 32'h7FFFFFFF : q;
      end
      return r;
   endfunction

   dv_type          d0_in, d0_ff;
   dv_type          src [QW];
   dv_type          st_in [QW];
   dv_type          st_ff [QW];
   logic [QW+1:0]   v_ff;
   out_type         fin_in, fin_ff;
   logic [31:0]     qt;
   logic [31:0]     ln [LANES];
   dv_type          last;

   always_comb begin
      d0_in      = '0;
      d0_in.side = in_data.side;
      d0_in.s    = in_data.side.wide ? {1'b0, in_data.root, 2'b00}
                                     : {2'b00, in_data.root, 1'b0};
      for (int l = 0; l < LANES; l++) begin
         d0_in.ovf[l] = in_data.side.mag[l] >= {d0_in.s, 2'b00};
         d0_in.rem[l] = REMW'(in_data.side.mag[l][MW-1:2]);
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      if (j == 0) begin : g_first
         assign src[j] = d0_ff;
      end else begin : g_next
         assign src[j] = st_ff[j-1];
      end

      always_comb begin
         logic [REMW-1:0] rs;
         logic            nb;
         logic            ge;
         st_in[j] = src[j];
         for (int l = 0; l < LANES; l++) begin
            nb = (j == 0) ? src[j].side.mag[l][1] :
                 (j == 1) ? src[j].side.mag[l][0] : 1'b0;
            rs = {src[j].rem[l][REMW-2:0], nb};
            ge = rs >= REMW'(src[j].s);
            st_in[j].rem[l] = ge ? rs - REMW'(src[j].s) : rs;
            st_in[j].quo[l] = {src[j].quo[l][QW-2:0], ge};
         end
      end
   end

   assign last = st_ff[QW-1];

   always_comb begin
      qt = (|last.s[SW-1:SW-2]) ? 32'h7FFFFFFF : {1'b0, last.s[SW-3:2]};
      for (int l = 0; l < LANES; l++) begin
         ln[l] = lane_fix(last.quo[l], last.ovf[l], last.side.neg[l]);
      end
      fin_in.pos = last.side.pos;
      unique case (last.side.big)
         BIG_W: fin_in.att = '{w: qt, x: ln[0], y: ln[1], z: ln[2]};
         BIG_X: fin_in.att = '{w: ln[0], x: qt, y: ln[1], z: ln[2]};
         BIG_Y: fin_in.att = '{w: ln[0], x: ln[1], y: qt, z: ln[2]};
         BIG_Z: fin_in.att = '{w: ln[0], x: ln[1], y: ln[2], z: qt};
      endcase
      if (last.side.zero) begin
         fin_in.att = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= d0_in;
         for (int j = 0; j < QW; j++) begin
            st_ff[j] <= st_in[j];
         end
         fin_ff <= fin_in;
      end
   end

   assign out_valid = v_ff[QW+1];
   assign out_data  = fin_ff;

endmodule

[sv/nep_skid.sv]
module nep_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  nep_pkg::out_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output nep_pkg::out_type out_data
);
   import nep_pkg::*;

   logic    out_valid_ff, skid_valid_ff;
   out_type out_ff, skid_ff;
   logic    push, pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;
   assign pop      = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push && out_valid_ff && !pop) begin
         skid_valid_ff <= 1'b1;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push && out_valid_ff && !pop) begin
         skid_ff <= in_data;
      end else if (push) begin
         out_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

[sv/ned_to_enu_pose_convert.sv]
// Pose converter, north-east-down / forward-right-down to east-north-up / forward-left-up.
// req_ch takes one pose word: Q16.16 position and Q2.30 attitude quaternion.
// rsp_ch gives one word per pose: swapped position, up saturated at the most negative
// down, and the converted quaternion rebuilt by the four-branch trace method.
// Throughput: one word per cycle while rsp_ch keeps taking words; a stall holds the pipe (see below).
// From req_ch to rsp_ch a word passes, in order, a product stage, a rotation-matrix
// stage and a branch stage; a 32-step root pipeline (one result bit per stage); then a
// divisor setup stage, 32 divide stages (one quotient bit per stage, three lanes), the
// packing stage and the output register.
// Backpressure: the output register and a one-word skid buffer sit behind the pipe;
// the pipe advances while the skid buffer is empty, so req_ch.ready stays high while a
// single word waits on rsp_ch and falls only once a second word is held back. A
// stall holds every stage in place.
// Reset clears all valid bits, including those of both output buffers; data registers are not reset.
module ned_to_enu_pose_convert (
   input logic       clock,
   input logic       reset,
   nep_req_if.sink   req_ch,
   nep_rsp_if.source rsp_ch
);
   import nep_pkg::*;

   logic    en;
   in_type  in_word;
   logic    fr_valid, rt_valid, dv_valid;
   fr_type  fr_word;
   rt_type  rt_word;
   out_type dv_word, rsp_word;

   assign in_word = '{pos_north: req_ch.pos_north, pos_east: req_ch.pos_east,
                      pos_down: req_ch.pos_down, att_w: req_ch.att_w, att_x: req_ch.att_x,
                      att_y: req_ch.att_y, att_z: req_ch.att_z};
   assign req_ch.ready = en;

   nep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_data   (in_word),
      .out_valid (fr_valid),
      .out_data  (fr_word)
   );

   nep_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_data   (fr_word),
      .out_valid (rt_valid),
      .out_data  (rt_word)
   );

   nep_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid),
      .in_data   (rt_word),
      .out_valid (dv_valid),
      .out_data  (dv_word)
   );

   nep_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (en),
      .in_data   (dv_word),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_word)
   );

   assign rsp_ch.enu_east  = rsp_word.pos.east;
   assign rsp_ch.enu_north = rsp_word.pos.north;
   assign rsp_ch.enu_up    = rsp_word.pos.up;
   assign rsp_ch.out_w     = rsp_word.att.w;
   assign rsp_ch.out_x     = rsp_word.att.x;
   assign rsp_ch.out_y     = rsp_word.att.y;
   assign rsp_ch.out_z     = rsp_word.att.z;

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("pipe stalled with no word waiting");

   a_pop_frees_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> req_ch.ready)
      else $error("pipe still stalled after a word was taken");

   a_up_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.enu_up != 32'sh80000000)
      else $error("up coordinate not saturated");

endmodule
